>>> sv/ssoi_pkg.sv
package ssoi_pkg;

  // table geometry
  localparam int unsigned MAX_ENTRIES = 1023;
  localparam int unsigned DEPTH       = MAX_ENTRIES + 1;
  localparam int unsigned ADDR_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W       = 11;

  // field widths
  localparam int unsigned OFF_W = 63;
  localparam int unsigned POS_W = 32;
  localparam int unsigned TS_W  = 48;
  localparam int unsigned REQ_W = 3;
  localparam int unsigned ENT_W = OFF_W + POS_W + TS_W;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_ADD   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FPOS  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FTS   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TRUNC = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;

  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [POS_W-1:0] pos;
    logic [TS_W-1:0]  ts;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_AT_CHK, S_SHIFT_RD, S_SHIFT_WR, S_INS_CHK,
    S_THIN_RD, S_THIN_WR, S_LAST_SAV, S_LAST_WR, S_FP_OUT, S_FT_OUT, S_PUSH
  } state_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_SRCH_RD, CMD_SRCH_UPD, CMD_AT_RD, CMD_WR_AT,
    CMD_SHIFT_RD, CMD_SHIFT_WR, CMD_INS, CMD_THIN_INIT, CMD_THIN_RD, CMD_THIN_WR,
    CMD_LAST_RD1, CMD_LAST_SAV, CMD_LAST_WR, CMD_FP_RD, CMD_FP_OUT, CMD_FT_RD,
    CMD_FT_OUT, CMD_TRUNC, CMD_CLEAR, CMD_PUSH
  } cmd_e;

  typedef struct packed {
    logic             srch_done;
    logic [REQ_W-1:0] req_type;
    logic             at_lt_cnt;
    logic             match;
    logic             ptr_gt_lo;
    logic             over_max;
    logic             thin_more;
    logic             fp_ok;
    logic             cnt_nz;
    logic             out_free;
  } status_t;

endpackage

>>> sv/ssoi_ram.sv
module ssoi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/ssoi_ctrl.sv
module ssoi_ctrl
  import ssoi_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t stat_i,
  output cmd_e    cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (!stat_i.srch_done) begin
          cmd_o   = CMD_SRCH_RD;
          state_d = S_SRCH_CMP;
        end else begin
          unique case (stat_i.req_type)
            REQ_ADD: begin
              cmd_o   = CMD_AT_RD;
              state_d = S_AT_CHK;
            end
            REQ_FPOS: begin
              if (stat_i.fp_ok) begin
                cmd_o   = CMD_FP_RD;
                state_d = S_FP_OUT;
              end else begin
                state_d = S_PUSH;
              end
            end
            REQ_FTS: begin
              if (stat_i.cnt_nz) begin
                cmd_o   = CMD_FT_RD;
                state_d = S_FT_OUT;
              end else begin
                state_d = S_PUSH;
              end
            end
            REQ_TRUNC: begin
              cmd_o   = CMD_TRUNC;
              state_d = S_PUSH;
            end
            REQ_CLEAR: begin
              cmd_o   = CMD_CLEAR;
              state_d = S_PUSH;
            end
            default: state_d = S_PUSH;
          endcase
        end
      end
      S_SRCH_CMP: begin
        cmd_o   = CMD_SRCH_UPD;
        state_d = S_SRCH_RD;
      end
      S_AT_CHK: begin
        if (stat_i.at_lt_cnt && stat_i.match) begin
          cmd_o   = CMD_WR_AT;
          state_d = S_PUSH;
        end else begin
          state_d = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        if (stat_i.ptr_gt_lo) begin
          cmd_o   = CMD_SHIFT_RD;
          state_d = S_SHIFT_WR;
        end else begin
          cmd_o   = CMD_INS;
          state_d = S_INS_CHK;
        end
      end
      S_SHIFT_WR: begin
        cmd_o   = CMD_SHIFT_WR;
        state_d = S_SHIFT_RD;
      end
      S_INS_CHK: begin
        if (stat_i.over_max) begin
          cmd_o   = CMD_THIN_INIT;
          state_d = S_THIN_RD;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_THIN_RD: begin
        if (stat_i.thin_more) begin
          cmd_o   = CMD_THIN_RD;
          state_d = S_THIN_WR;
        end else begin
          cmd_o   = CMD_LAST_RD1;
          state_d = S_LAST_SAV;
        end
      end
      S_THIN_WR: begin
        cmd_o   = CMD_THIN_WR;
        state_d = S_THIN_RD;
      end
      S_LAST_SAV: begin
        cmd_o   = CMD_LAST_SAV;
        state_d = S_LAST_WR;
      end
      S_LAST_WR: begin
        cmd_o   = CMD_LAST_WR;
        state_d = S_PUSH;
      end
      S_FP_OUT: begin
        cmd_o   = CMD_FP_OUT;
        state_d = S_PUSH;
      end
      S_FT_OUT: begin
        cmd_o   = CMD_FT_OUT;
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (stat_i.out_free) begin
          cmd_o   = CMD_PUSH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> sv/ssoi_dp.sv
module ssoi_dp
  import ssoi_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_e             cmd_i,
  output status_t          stat_o,
  input  logic [REQ_W-1:0] req_type_i,
  input  logic [OFF_W-1:0] offset_key_i,
  input  logic [POS_W-1:0] position_value_i,
  input  logic [TS_W-1:0]  timestamp_value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             found_o,
  output logic [OFF_W-1:0] out_offset_o,
  output logic [POS_W-1:0] out_position_o,
  output logic [CNT_W-1:0] num_entries_o
);

  logic [REQ_W-1:0] type_q;
  logic [OFF_W-1:0] key_q;
  logic [POS_W-1:0] pos_q;
  logic [TS_W-1:0]  ts_q;
  logic [CNT_W-1:0] cnt_q, lo_q, hi_q, ptr_q, wr_q, old_q;
  logic [OFF_W-1:0] sav_q;
  logic             found_q;
  logic [OFF_W-1:0] ooff_q;
  logic [POS_W-1:0] opos_q;
  logic             ovld_q, ofound_q;
  logic [OFF_W-1:0] o_off_q;
  logic [POS_W-1:0] o_pos_q;
  logic [CNT_W-1:0] o_cnt_q;

  logic [CNT_W-1:0] mid, rd_idx, wr_idx;
  logic             rd_en, wr_en, go_right, differ, is_srch;
  entry_t           rdata, wdata, new_ent;

  assign mid      = lo_q + ((hi_q - lo_q) >> 1);
  assign new_ent  = '{off: key_q, pos: pos_q, ts: ts_q};
  assign differ   = (rdata.off != sav_q);
  assign is_srch  = (req_type_i == REQ_ADD) || (req_type_i == REQ_FPOS) ||
                    (req_type_i == REQ_FTS) || (req_type_i == REQ_TRUNC);

  // search direction per request kind
  always_comb begin
    case (type_q)
      REQ_FPOS: go_right = (rdata.off <= key_q);
      REQ_FTS:  go_right = (rdata.ts < ts_q);
      default:  go_right = (rdata.off < key_q);
    endcase
  end

  // memory port selection
  always_comb begin
    rd_en  = 1'b1;
    wr_en  = 1'b0;
    rd_idx = '0;
    wr_idx = '0;
    wdata  = rdata;
    case (cmd_i)
      CMD_SRCH_RD:  rd_idx = mid;
      CMD_AT_RD:    rd_idx = lo_q;
      CMD_SHIFT_RD: rd_idx = ptr_q - 1'b1;
      CMD_THIN_RD:  rd_idx = ptr_q;
      CMD_LAST_RD1: rd_idx = wr_q - 1'b1;
      CMD_LAST_SAV: rd_idx = old_q - 1'b1;
      CMD_FP_RD:    rd_idx = lo_q - 1'b1;
      CMD_FT_RD:    rd_idx = (lo_q < cnt_q) ? lo_q : cnt_q - 1'b1;
      CMD_WR_AT, CMD_INS: begin
        rd_en  = 1'b0;
        wr_en  = 1'b1;
        wr_idx = lo_q;
        wdata  = new_ent;
      end
      CMD_SHIFT_WR: begin
        rd_en  = 1'b0;
        wr_en  = 1'b1;
        wr_idx = ptr_q;
      end
      CMD_THIN_WR: begin
        rd_en  = 1'b0;
        wr_en  = 1'b1;
        wr_idx = wr_q;
      end
      CMD_LAST_WR: begin
        rd_en  = 1'b0;
        wr_en  = differ;
        wr_idx = wr_q;
      end
      default: rd_en = 1'b0;
    endcase
  end

  ssoi_ram #(
    .WIDTH(ENT_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_idx[ADDR_W-1:0]),
    .wr_data_i(wdata),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_idx[ADDR_W-1:0]),
    .rd_data_o(rdata)
  );

  // request fields
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD) begin
      type_q <= req_type_i;
      key_q  <= offset_key_i;
      pos_q  <= position_value_i;
      ts_q   <= timestamp_value_i;
    end
    if (cmd_i == CMD_LAST_SAV) begin
      sav_q <= rdata.off;
    end
  end

  // control registers and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      ptr_q   <= '0;
      wr_q    <= '0;
      old_q   <= '0;
      found_q <= 1'b0;
      ooff_q  <= '0;
      opos_q  <= '0;
    end else begin
      case (cmd_i)
        CMD_LOAD: begin
          lo_q    <= '0;
          hi_q    <= is_srch ? cnt_q : '0;
          found_q <= 1'b0;
          ooff_q  <= '0;
          opos_q  <= '0;
        end
        CMD_SRCH_UPD: begin
          if (go_right) begin
            lo_q <= mid + 1'b1;
          end else begin
            hi_q <= mid;
          end
        end
        CMD_AT_RD:    ptr_q <= cnt_q;
        CMD_SHIFT_WR: ptr_q <= ptr_q - 1'b1;
        CMD_INS:      cnt_q <= cnt_q + 1'b1;
        CMD_THIN_INIT: begin
          old_q <= cnt_q;
          wr_q  <= CNT_W'(1);
          ptr_q <= CNT_W'(2);
        end
        CMD_THIN_WR: begin
          wr_q  <= wr_q + 1'b1;
          ptr_q <= ptr_q + CNT_W'(2);
        end
        CMD_LAST_WR: cnt_q <= wr_q + CNT_W'(differ);
        CMD_FP_OUT: begin
          found_q <= 1'b1;
          opos_q  <= rdata.pos;
        end
        CMD_FT_OUT: begin
          found_q <= 1'b1;
          ooff_q  <= rdata.off;
        end
        CMD_TRUNC: cnt_q <= lo_q;
        CMD_CLEAR: cnt_q <= '0;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (cmd_i == CMD_PUSH) begin
      ovld_q <= 1'b1;
    end else if (out_ready_i) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_PUSH) begin
      ofound_q <= found_q;
      o_off_q  <= ooff_q;
      o_pos_q  <= opos_q;
      o_cnt_q  <= cnt_q;
    end
  end

  assign out_valid_o    = ovld_q;
  assign found_o        = ofound_q;
  assign out_offset_o   = o_off_q;
  assign out_position_o = o_pos_q;
  assign num_entries_o  = o_cnt_q;

  // status to controller
  assign stat_o.srch_done = (lo_q == hi_q);
  assign stat_o.req_type  = type_q;
  assign stat_o.at_lt_cnt = (lo_q < cnt_q);
  assign stat_o.match     = (rdata.off == key_q);
  assign stat_o.ptr_gt_lo = (ptr_q > lo_q);
  assign stat_o.over_max  = (cnt_q > CNT_W'(MAX_ENTRIES));
  assign stat_o.thin_more = (ptr_q < old_q - 1'b1);
  assign stat_o.fp_ok     = (cnt_q != '0) && (lo_q != '0);
  assign stat_o.cnt_nz    = (cnt_q != '0);
  assign stat_o.out_free  = !ovld_q || out_ready_i;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH)) else $error("entry count beyond table depth");
  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q <= hi_q) else $error("search bounds crossed");
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_INS |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("insert did not grow the table");
  a_no_push_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_PUSH) |-> (!ovld_q || out_ready_i))
    else $error("result pushed over a pending one");

endmodule

>>> sv/sorted_sparse_offset_index.sv
// an add that overflows the table adds a compaction pass
// requests are handled one at a time; a new request is taken only while the controller is idle
// the result register frees the input side while a result waits to be taken
// reset empties the table; table contents are not cleared
module sorted_sparse_offset_index
  import ssoi_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [143:0]   s_axis_tdata,  // offset_key, position_value, timestamp_value
  input  logic [REQ_W-1:0] s_axis_tuser,  // req_type
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [111:0]   m_axis_tdata,  // out_offset, out_position, entry count
  output logic           m_axis_tuser   // found
);

  cmd_e             cmd;
  status_t          stat;
  logic             rdy;
  logic [OFF_W-1:0] out_off;
  logic [POS_W-1:0] out_pos;
  logic [CNT_W-1:0] out_cnt;

  ssoi_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(rdy),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  ssoi_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .req_type_i       (s_axis_tuser),
    .offset_key_i     (s_axis_tdata[62:0]),
    .position_value_i (s_axis_tdata[94:63]),
    .timestamp_value_i(s_axis_tdata[142:95]),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .found_o          (m_axis_tuser),
    .out_offset_o     (out_off),
    .out_position_o   (out_pos),
    .num_entries_o    (out_cnt)
  );

  assign s_axis_tready = rdy;
  assign m_axis_tdata  = {6'd0, out_cnt, out_pos, out_off};

endmodule
